@@ rtl/core/insertion_sorter_defines.svh @@
// ----------------------------------------------------------------------------
// Insertion sorter assertion macros
// Shared property macros for the sorter RTL; they vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication under a synchronous reset.
`define INS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous reset.
`define INS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define INS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define INS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/ins_pkg.sv @@
// ----------------------------------------------------------------------------
// Insertion sorter package
// Beat payloads, controller states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ins_pkg;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               batch_end;
   } ins_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sorted_value;
      logic               run_end;
   } ins_rsp_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } ins_state_type;

   // Control handed from the controller to one cell of the row.
   typedef struct packed {
      logic insert;    // a new value is placed this cycle
      logic shift;     // the row moves one place toward the output
      logic occupied;  // the cell holds a value of the current batch
      logic tail;      // the cell is the first free place of the row
   } ins_cell_ctl_type;

endpackage

@@ rtl/core/ins_stream_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface ins_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/ins_cell.sv @@
// ----------------------------------------------------------------------------
// Insertion sorter cell
// Holds one value of the sorted row. On an insert it keeps its value, takes
// its lower neighbor's value or takes the new value; on a shift it takes its
// upper neighbor's value.
// ----------------------------------------------------------------------------
module ins_cell (
   input  logic                          clock,
   input  ins_pkg::ins_cell_ctl_type     ctl,
   input  logic [ins_pkg::VALUE_W-1:0]   new_value,
   input  logic [ins_pkg::VALUE_W-1:0]   left_value,
   input  logic                          left_gt,
   input  logic [ins_pkg::VALUE_W-1:0]   right_value,
   output logic [ins_pkg::VALUE_W-1:0]   value,
   output logic                          gt
);

   logic [ins_pkg::VALUE_W-1:0] value_ff;
   logic [ins_pkg::VALUE_W-1:0] value_in;

   // Strictly greater keeps equal values in arrival order.
   assign gt = ctl.occupied && (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      priority if (ctl.insert && (gt || ctl.tail)) begin
         value_in = left_gt ? left_value : new_value;
      end else if (ctl.shift) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/core/insertion_sorter.sv @@
// ----------------------------------------------------------------------------
// Insertion sorter
// Collects a batch of unsigned 32-bit values and returns them in ascending
// order. A row of SIZE cells keeps the batch sorted as it arrives: each
// accepted value lands behind every held value no greater than it. The batch
// closes on a beat with batch_end set or when the row is full; the row then
// shifts toward the output one place per returned beat, with run_end on the
// largest value. No value is accepted while draining.
// ----------------------------------------------------------------------------
`include "insertion_sorter_defines.svh"

module insertion_sorter #(
   parameter int SIZE = 16
) (
   input  logic         clock,
   input  logic         reset,
   ins_stream_if.sink   req_bus,
   ins_stream_if.source rsp_bus
);

   localparam int CNT_W = $clog2(SIZE + 1);

   ins_pkg::ins_state_type state_ff;
   ins_pkg::ins_state_type state_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   logic req_ready;
   logic rsp_valid;
   logic req_acc;
   logic rsp_acc;

   logic [ins_pkg::VALUE_W-1:0] cell_value [SIZE];
   logic [SIZE-1:0]             cell_gt;

   assign req_ready = (state_ff == ins_pkg::ST_COLLECT);
   assign rsp_valid = (state_ff == ins_pkg::ST_DRAIN);

   assign req_acc = req_bus.valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_bus.ready;

   // The row of cells.
   for (genvar i = 0; i < SIZE; i++) begin : g_cell
      ins_pkg::ins_cell_ctl_type   ctl;
      logic [ins_pkg::VALUE_W-1:0] left_value;
      logic                        left_gt;
      logic [ins_pkg::VALUE_W-1:0] right_value;

      assign ctl.insert   = req_acc;
      assign ctl.shift    = rsp_acc;
      assign ctl.occupied = CNT_W'(i) < count_ff;
      assign ctl.tail     = CNT_W'(i) == count_ff;

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_gt    = 1'b0;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == SIZE - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_lower
         assign right_value = cell_value[i+1];
      end

      ins_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_value   (req_bus.payload.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // Controller: the count is the fill level while collecting and the
   // number of beats left while draining.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ins_pkg::ST_COLLECT: begin
            if (req_acc) begin
               count_in = count_ff + CNT_W'(1);
               if (req_bus.payload.batch_end ||
                   (count_ff + CNT_W'(1) == CNT_W'(SIZE))) begin
                  state_in = ins_pkg::ST_DRAIN;
               end
            end
         end
         ins_pkg::ST_DRAIN: begin
            if (rsp_acc) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ins_pkg::ST_COLLECT;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ins_pkg::ST_COLLECT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign req_bus.ready                = req_ready;
   assign rsp_bus.valid                = rsp_valid;
   assign rsp_bus.payload.sorted_value = cell_value[0];
   assign rsp_bus.payload.run_end      = count_ff == CNT_W'(1);

   `INS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1,
      count_ff <= CNT_W'(SIZE), "count beyond row size")
   `INS_ASSERT_NEXT(a_batch_close, clock, reset,
      req_acc && req_bus.payload.batch_end, rsp_bus.valid && !req_bus.ready,
      "batch end did not start the drain")
   `INS_ASSERT_NEXT(a_ascending, clock, reset,
      rsp_acc && !rsp_bus.payload.run_end,
      rsp_bus.valid &&
      (rsp_bus.payload.sorted_value >= $past(rsp_bus.payload.sorted_value)),
      "drained beats out of order")
   `INS_ASSERT_NEXT(a_drain_done, clock, reset,
      rsp_acc && rsp_bus.payload.run_end,
      req_bus.ready && !rsp_bus.valid && (count_ff == '0),
      "drain did not return to collecting")

endmodule
